[design/slkc_pkg.sv]
// ----------------------------------------------------------------------------
// slkc_pkg
// Shared constants, result type and keyword table for the SQL leading
// keyword classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slkc_pkg;

  localparam int unsigned MaxWordLen = 8;
  localparam int unsigned StoreLen   = 8;
  localparam int unsigned CntW       = $clog2(MaxWordLen + 2);
  localparam int unsigned LettersW   = 8 * StoreLen;
  localparam int unsigned NumKw      = 8;

  localparam logic [3:0] KwNone    = 4'd0;
  localparam logic [3:0] KwSelect  = 4'd1;
  localparam logic [3:0] KwWith    = 4'd6;
  localparam logic [3:0] KwInsert  = 4'd7;
  localparam logic [3:0] KwReplace = 4'd8;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] UpMask  = 8'hDF;

  typedef struct packed {
    logic [3:0] keyword_id;
    logic       is_query;
    logic       is_insert;
    logic [3:0] word_length;
  } result_t;

  // letter i sits in bits 8i+7..8i
  function automatic logic [LettersW-1:0] kw_word(input logic [2:0] idx);
    logic [LettersW-1:0] w;
    w = '0;
    unique case (idx)
      3'd0: w[47:0] = {"T", "C", "E", "L", "E", "S"};
      3'd1: w[31:0] = {"W", "O", "H", "S"};
      3'd2: w[31:0] = {"C", "S", "E", "D"};
      3'd3: w[63:0] = {"E", "B", "I", "R", "C", "S", "E", "D"};
      3'd4: w[55:0] = {"N", "I", "A", "L", "P", "X", "E"};
      3'd5: w[31:0] = {"H", "T", "I", "W"};
      3'd6: w[47:0] = {"T", "R", "E", "S", "N", "I"};
      3'd7: w[55:0] = {"E", "C", "A", "L", "P", "E", "R"};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [CntW-1:0] kw_len(input logic [2:0] idx);
    logic [CntW-1:0] n;
    unique case (idx)
      3'd0, 3'd6: n = CntW'(6);
      3'd1, 3'd2, 3'd5: n = CntW'(4);
      3'd3: n = CntW'(8);
      3'd4, 3'd7: n = CntW'(7);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[design/slkc_match.sv]
// ----------------------------------------------------------------------------
// slkc_match
// Matches the gathered upper-case word against the keyword table and
// builds the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slkc_match (
  input  logic [slkc_pkg::LettersW-1:0] letters_i,
  input  logic [slkc_pkg::CntW-1:0]     count_i,
  input  logic                          with_word_i,
  output slkc_pkg::result_t             result_o
);

  logic       len_ok;
  logic [3:0] id;
  logic [3:0] len_capped;

  always_comb begin
    len_ok = with_word_i && (count_i != '0)
             && (32'(count_i) <= slkc_pkg::MaxWordLen)
             && (32'(count_i) <= slkc_pkg::StoreLen);
    id = slkc_pkg::KwNone;
    for (int k = slkc_pkg::NumKw - 1; k >= 0; k--) begin
      if (len_ok && count_i == slkc_pkg::kw_len(3'(k))
          && letters_i == slkc_pkg::kw_word(3'(k))) begin
        id = 4'(k + 1);
      end
    end
    if (!with_word_i) begin
      len_capped = 4'd0;
    end else if (32'(count_i) > 15) begin
      len_capped = 4'd15;
    end else begin
      len_capped = 4'(count_i);
    end
  end

  assign result_o.keyword_id  = id;
  assign result_o.is_query    = (id >= slkc_pkg::KwSelect) && (id <= slkc_pkg::KwWith);
  assign result_o.is_insert   = (id == slkc_pkg::KwInsert) || (id == slkc_pkg::KwReplace);
  assign result_o.word_length = len_capped;

endmodule

`default_nettype wire

[design/slkc_scan.sv]
// ----------------------------------------------------------------------------
// slkc_scan
// Per-byte scanner: skips blanks and comments, gathers the first word and
// flags when the single result of a statement is due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slkc_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        text_byte_i,
  input  logic              last_byte_i,
  output logic              emit_o,
  output slkc_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    PhSkip  = 3'd0,
    PhDash  = 3'd1,
    PhSlash = 3'd2,
    PhLine  = 3'd3,
    PhBlock = 3'd4,
    PhWord  = 3'd5,
    PhDone  = 3'd6
  } phase_e;

  phase_e                          phase_q, phase_d, phase_step;
  logic                            star_q, star_d;
  logic [slkc_pkg::LettersW-1:0]   letters_q, letters_d;
  logic [slkc_pkg::CntW-1:0]       count_q, count_d;
  logic                            emit, with_word;
  logic                            is_letter;
  logic [7:0]                      up;

  assign up        = text_byte_i & slkc_pkg::UpMask;
  assign is_letter = (up >= 8'h41) && (up <= 8'h5A);

  always_comb begin
    phase_step = phase_q;
    star_d     = star_q;
    letters_d  = letters_q;
    count_d    = count_q;
    emit       = 1'b0;
    with_word  = 1'b0;
    unique case (phase_q)
      PhSkip: begin
        if (text_byte_i <= slkc_pkg::ChSpace) begin
          phase_step = PhSkip;
        end else if (text_byte_i == slkc_pkg::ChDash) begin
          phase_step = PhDash;
        end else if (text_byte_i == slkc_pkg::ChHash) begin
          phase_step = PhLine;
        end else if (text_byte_i == slkc_pkg::ChSlash) begin
          phase_step = PhSlash;
        end else if (is_letter) begin
          letters_d  = {{(slkc_pkg::LettersW - 8){1'b0}}, up};
          count_d    = slkc_pkg::CntW'(1);
          phase_step = PhWord;
        end else begin
          emit = 1'b1;
        end
      end
      PhDash: begin
        if (text_byte_i == slkc_pkg::ChDash) phase_step = PhLine;
        else emit = 1'b1;
      end
      PhSlash: begin
        if (text_byte_i == slkc_pkg::ChStar) begin
          phase_step = PhBlock;
          star_d     = 1'b0;
        end else begin
          emit = 1'b1;
        end
      end
      PhLine: begin
        if (text_byte_i == slkc_pkg::ChLf || text_byte_i == slkc_pkg::ChCr) begin
          phase_step = PhSkip;
        end
      end
      PhBlock: begin
        if (star_q && text_byte_i == slkc_pkg::ChSlash) begin
          phase_step = PhSkip;
          star_d     = 1'b0;
        end else begin
          star_d = (text_byte_i == slkc_pkg::ChStar);
        end
      end
      PhWord: begin
        if (is_letter) begin
          for (int i = 0; i < slkc_pkg::StoreLen; i++) begin
            if (count_q == slkc_pkg::CntW'(i)) letters_d[8*i +: 8] = up;
          end
          if (32'(count_q) < slkc_pkg::MaxWordLen + 1) begin
            count_d = count_q + slkc_pkg::CntW'(1);
          end
        end else begin
          emit      = 1'b1;
          with_word = 1'b1;
        end
      end
      default: begin
        phase_step = phase_q;
      end
    endcase
    // final byte forces the answer if none was given yet
    if (last_byte_i && !emit && phase_q != PhDone && phase_q != 3'd7) begin
      emit      = 1'b1;
      with_word = (phase_step == PhWord);
    end
    phase_d = emit ? PhDone : phase_step;
  end

  slkc_match u_match (
    .letters_i   (letters_d),
    .count_i     (count_d),
    .with_word_i (with_word),
    .result_o    (result_o)
  );

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSkip;
      star_q    <= 1'b0;
      letters_q <= '0;
      count_q   <= '0;
    end else if (en_i) begin
      if (last_byte_i) begin
        phase_q   <= PhSkip;
        star_q    <= 1'b0;
        letters_q <= '0;
        count_q   <= '0;
      end else begin
        phase_q   <= phase_d;
        star_q    <= star_d;
        letters_q <= letters_d;
        count_q   <= count_d;
      end
    end
  end

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && emit && !last_byte_i |=> phase_q == PhDone)
    else $error("phase not done after result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last_byte_i |=> phase_q == PhSkip && count_q == '0 && !star_q)
    else $error("state not cleared after final byte");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= slkc_pkg::MaxWordLen + 1)
    else $error("letter count out of range");

  a_one_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |-> !emit)
    else $error("second result for one statement");

endmodule

`default_nettype wire

[design/sql_leading_keyword_classifier_unit.sv]
// ----------------------------------------------------------------------------
// sql_leading_keyword_classifier_unit
// Classifies the leading keyword of an SQL statement streamed byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one text byte per request; tlast marks the final
//   byte of a statement. Leading blanks and comments are skipped, the first
//   word is gathered and matched. One result request per statement appears on
//   the master channel when the word ends, at a byte that cannot begin a word
//   or comment, or at the final byte. The accepted byte sits in the input
//   register, passes the scan logic and lands in the result register.
//   Throughput: one byte per cycle unless a pending result stalls; the scan
//   state update is combinational logic, so bytes may follow back to back.
//   Stall: when the receiver holds m_axis_tready low with a result pending,
//   the scan halts and s_axis_tready drops once the input register is full.
//   Reset: all scan state returns to blank skipping, both registers empty.
//   After the final byte the scan state clears for the next statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sql_leading_keyword_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] keyword_id, [7:4] word_length
  output logic [1:0] m_axis_tuser    // [0] is_query, [1] is_insert
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_valid_q;
  slkc_pkg::result_t out_q;
  slkc_pkg::result_t result;
  logic              emit;
  logic              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  slkc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .text_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.word_length, out_q.keyword_id};
  assign m_axis_tuser  = {out_q.is_insert, out_q.is_query};

  a_in_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_valid_q)
    else $error("accepted byte not held in input register");

  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result is both query and insert");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !advance)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
